>>> sv/pstq_pkg.sv
// ----------------------------------------------------------------------------
// pstq_pkg
// shared op codes, status codes and controller state encoding for the
// priority stack to queue block
// ----------------------------------------------------------------------------
package pstq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK_BOT = 3'd2,
        OP_REORDER  = 3'd3,
        OP_MOVE     = 3'd4,
        OP_PEEK_Q   = 3'd5,
        OP_DEQUEUE  = 3'd6,
        OP_NONE     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_RD   = 7'b0000100,
        S_P1   = 7'b0001000,
        S_P2   = 7'b0010000,
        S_MV   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam int unsigned OUT_NUM_BITS = 16;

endpackage

>>> sv/priority_stack_to_queue.sv
// ----------------------------------------------------------------------------
// priority_stack_to_queue
// stack and queue of records (number plus two-level priority) held in
// three rams, with stable priority reorder and stack to queue move
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_ready | i_op, i_record_number, i_low_priority
//   output  | o_valid | i_ready | o_status, o_out_number,
//           |         |         | o_out_low_priority, o_out_valid
//
// push, pop, status-only ops: go from the exec state straight to the result register
// peeks and dequeue: also pass the read state, for the registered ram read
// move: one stack read per entry into the queue ram
// reorder: copy to scratch ram then partition back
// reset is synchronous; rams need no clearing pass
// a new word is taken once the previous result sits in the output register
// ----------------------------------------------------------------------------
module priority_stack_to_queue #(
    parameter int DEPTH       = 16,
    parameter int NUMBER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_record_number,
    input  logic        i_low_priority,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_number,
    output logic        o_out_low_priority,
    output logic        o_out_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = NUMBER_BITS + 1;

    pstq_pkg::t_state  r_state, n_state;
    pstq_pkg::t_op     r_op, n_op;
    logic [NUMBER_BITS-1:0] r_num, n_num;
    logic              r_lo, n_lo;
    logic [CW-1:0]     r_scnt, n_scnt;
    logic [CW-1:0]     r_qcnt, n_qcnt;
    logic [AW-1:0]     r_qhead, n_qhead;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_rv, n_rv;
    logic [AW-1:0]     r_ridx, n_ridx;
    logic [CW-1:0]     r_nlow, n_nlow;
    logic [CW-1:0]     r_kl, n_kl;
    logic [CW-1:0]     r_kh, n_kh;
    pstq_pkg::t_status r_res_st, n_res_st;
    logic [NUMBER_BITS-1:0] r_res_num, n_res_num;
    logic              r_res_lo, n_res_lo;
    logic              r_res_ov, n_res_ov;
    logic              r_o_valid, n_o_valid;
    pstq_pkg::t_status r_o_st, n_o_st;
    logic [NUMBER_BITS-1:0] r_o_num, n_o_num;
    logic              r_o_lo, n_o_lo;
    logic              r_o_ov, n_o_ov;

    logic          s_we, c_we, q_we;
    logic [AW-1:0] s_waddr, s_raddr, c_waddr, q_waddr;
    logic [RW-1:0] s_wdata, c_wdata, q_wdata;
    logic [RW-1:0] s_rdata, c_rdata, q_rdata;
    logic [RW-1:0] w_rec;
    logic          w_rd_go;
    logic [CW-1:0] w_mv_addr;
    logic [CW-1:0] w_hi_addr;
    logic [31:0]   w_in32;
    logic [31:0]   w_out32;

    assign w_in32    = {16'd0, i_record_number};
    assign w_out32   = 32'(r_o_num);
    assign w_rd_go   = (r_idx != r_scnt);
    assign w_mv_addr = r_scnt - CW'(1) - r_idx;
    assign w_hi_addr = r_nlow + r_kh;

    pstq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    pstq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_scratch (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (c_rdata)
    );

    pstq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (r_qhead),
        .o_rdata (q_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_num     = r_num;
        n_lo      = r_lo;
        n_scnt    = r_scnt;
        n_qcnt    = r_qcnt;
        n_qhead   = r_qhead;
        n_idx     = r_idx;
        n_rv      = r_rv;
        n_ridx    = r_ridx;
        n_nlow    = r_nlow;
        n_kl      = r_kl;
        n_kh      = r_kh;
        n_res_st  = r_res_st;
        n_res_num = r_res_num;
        n_res_lo  = r_res_lo;
        n_res_ov  = r_res_ov;
        n_o_valid = r_o_valid;
        n_o_st    = r_o_st;
        n_o_num   = r_o_num;
        n_o_lo    = r_o_lo;
        n_o_ov    = r_o_ov;
        s_we      = 1'b0;
        s_waddr   = r_scnt[AW-1:0];
        s_wdata   = {r_lo, r_num};
        s_raddr   = '0;
        c_we      = 1'b0;
        c_waddr   = r_ridx;
        c_wdata   = s_rdata;
        q_we      = 1'b0;
        q_waddr   = r_ridx;
        q_wdata   = s_rdata;
        w_rec     = (r_op == pstq_pkg::OP_PEEK_BOT) ? s_rdata : q_rdata;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            pstq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op    = pstq_pkg::t_op'(i_op);
                    n_num   = w_in32[NUMBER_BITS-1:0];
                    n_lo    = i_low_priority;
                    n_state = pstq_pkg::S_EXEC;
                end
            end
            pstq_pkg::S_EXEC: begin
                n_res_st  = pstq_pkg::ST_DONE;
                n_res_num = '0;
                n_res_lo  = 1'b0;
                n_res_ov  = 1'b0;
                n_state   = pstq_pkg::S_DONE;
                n_idx     = '0;
                n_rv      = 1'b0;
                n_nlow    = '0;
                unique case (r_op)
                    pstq_pkg::OP_PUSH: begin
                        if (r_scnt == CW'(DEPTH)) begin
                            n_res_st = pstq_pkg::ST_FULL;
                        end else begin
                            s_we   = 1'b1;
                            n_scnt = r_scnt + CW'(1);
                        end
                    end
                    pstq_pkg::OP_POP: begin
                        if (r_scnt == '0) begin
                            n_res_st = pstq_pkg::ST_EMPTY;
                        end else begin
                            n_scnt = r_scnt - CW'(1);
                        end
                    end
                    pstq_pkg::OP_PEEK_BOT: begin
                        if (r_scnt == '0) begin
                            n_res_st = pstq_pkg::ST_EMPTY;
                        end else begin
                            n_state = pstq_pkg::S_RD;
                        end
                    end
                    pstq_pkg::OP_REORDER: begin
                        if (r_scnt == '0) begin
                            n_res_st = pstq_pkg::ST_EMPTY;
                        end else begin
                            n_state = pstq_pkg::S_P1;
                        end
                    end
                    pstq_pkg::OP_MOVE: begin
                        if (r_scnt == '0) begin
                            n_res_st = pstq_pkg::ST_EMPTY;
                        end else begin
                            n_state = pstq_pkg::S_MV;
                        end
                    end
                    pstq_pkg::OP_PEEK_Q, pstq_pkg::OP_DEQUEUE: begin
                        if (r_qcnt == '0) begin
                            n_res_st = pstq_pkg::ST_EMPTY;
                        end else begin
                            n_state = pstq_pkg::S_RD;
                            if (r_op == pstq_pkg::OP_DEQUEUE) begin
                                n_qcnt  = r_qcnt - CW'(1);
                                n_qhead = (r_qhead == AW'(DEPTH - 1)) ? '0
                                                                      : r_qhead + AW'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pstq_pkg::S_RD: begin
                n_res_num = w_rec[NUMBER_BITS-1:0];
                n_res_lo  = w_rec[NUMBER_BITS];
                n_res_ov  = 1'b1;
                n_state   = pstq_pkg::S_DONE;
            end
            pstq_pkg::S_P1, pstq_pkg::S_P2, pstq_pkg::S_MV: begin
                n_idx  = r_idx + CW'(w_rd_go);
                n_rv   = w_rd_go;
                n_ridx = r_idx[AW-1:0];
                if (r_state == pstq_pkg::S_MV) begin
                    s_raddr = w_mv_addr[AW-1:0];
                end else begin
                    s_raddr = r_idx[AW-1:0];
                end
                if (r_rv) begin
                    if (r_state == pstq_pkg::S_P1) begin
                        c_we = 1'b1;
                        if (s_rdata[NUMBER_BITS]) begin
                            n_nlow = r_nlow + CW'(1);
                        end
                    end else if (r_state == pstq_pkg::S_P2) begin
                        s_we    = 1'b1;
                        s_wdata = c_rdata;
                        if (c_rdata[NUMBER_BITS]) begin
                            s_waddr = r_kl[AW-1:0];
                            n_kl    = r_kl + CW'(1);
                        end else begin
                            s_waddr = w_hi_addr[AW-1:0];
                            n_kh    = r_kh + CW'(1);
                        end
                    end else begin
                        q_we = 1'b1;
                    end
                end
                if (!w_rd_go && !r_rv) begin
                    if (r_state == pstq_pkg::S_P1) begin
                        n_state = pstq_pkg::S_P2;
                        n_idx   = '0;
                        n_kl    = '0;
                        n_kh    = '0;
                    end else if (r_state == pstq_pkg::S_P2) begin
                        n_state = pstq_pkg::S_DONE;
                    end else begin
                        n_qhead = '0;
                        n_qcnt  = r_scnt;
                        n_scnt  = '0;
                        n_state = pstq_pkg::S_DONE;
                    end
                end
            end
            pstq_pkg::S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_res_st;
                    n_o_num   = r_res_num;
                    n_o_lo    = r_res_lo;
                    n_o_ov    = r_res_ov;
                    n_state   = pstq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pstq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pstq_pkg::S_IDLE;
            r_scnt    <= '0;
            r_qcnt    <= '0;
            r_qhead   <= '0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scnt    <= n_scnt;
            r_qcnt    <= n_qcnt;
            r_qhead   <= n_qhead;
            r_rv      <= n_rv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_num     <= n_num;
        r_lo      <= n_lo;
        r_idx     <= n_idx;
        r_ridx    <= n_ridx;
        r_nlow    <= n_nlow;
        r_kl      <= n_kl;
        r_kh      <= n_kh;
        r_res_st  <= n_res_st;
        r_res_num <= n_res_num;
        r_res_lo  <= n_res_lo;
        r_res_ov  <= n_res_ov;
        r_o_st    <= n_o_st;
        r_o_num   <= n_o_num;
        r_o_lo    <= n_o_lo;
        r_o_ov    <= n_o_ov;
    end

    assign o_ready            = (r_state == pstq_pkg::S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_status           = r_o_st;
    assign o_out_number       = w_out32[pstq_pkg::OUT_NUM_BITS-1:0];
    assign o_out_low_priority = r_o_lo;
    assign o_out_valid        = r_o_ov;

endmodule

>>> sv/pstq_ram.sv
// ----------------------------------------------------------------------------
// pstq_ram
// generic simple dual port ram, one write port, one read port with
// registered read data
// ----------------------------------------------------------------------------
module pstq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for priority_stack_to_queue: directed words cover empty
// cases, the unused op and the extreme record values, then random push bursts, moves
// and drains run against a cycle-free behavioural model of the stack and queue,
// with bursty input, a patterned output stall and long output hold-offs
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pstq_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int NUM_BITS     = 16;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [15:0] NUM_MASK = 16'((17'd1 << NUM_BITS) - 1);

    typedef struct packed {
        logic [15:0] number;
        logic        low;
    } t_record;

    typedef struct packed {
        t_op         op;
        logic [15:0] number;
        logic        low;
    } t_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] number;
        logic        low;
        logic        valid;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_op         i_op = OP_NONE;
    logic [15:0] i_record_number = 16'd0;
    logic        i_low_priority = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_out_number;
    logic        o_out_low_priority;
    logic        o_out_valid;

    t_word    words_to_send[$];
    t_outcome pending_results[$];
    int       words_total;
    int       words_in = 0;
    int       err_count = 0;
    int       counted_words = 0;
    logic     in_taken = 1'b0;

    // model state
    t_record     stack_mem[STACK_DEPTH];
    t_record     scratch_mem[STACK_DEPTH];
    t_record     queue_mem[STACK_DEPTH];
    int unsigned stack_count = 0;
    int unsigned queue_head = 0;
    int unsigned queue_count = 0;

    priority_stack_to_queue #(
        .DEPTH      (STACK_DEPTH),
        .NUMBER_BITS(NUM_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_record_number   (i_record_number),
        .i_low_priority    (i_low_priority),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_out_number      (o_out_number),
        .o_out_low_priority(o_out_low_priority),
        .o_out_valid       (o_out_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_outcome stack_queue_result(t_op op, logic [15:0] number, logic low);
        t_outcome res;
        int unsigned k;
        res = '{status: ST_DONE, number: 16'd0, low: 1'b0, valid: 1'b0};
        case (op)
            OP_PUSH: begin
                if (stack_count >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_mem[stack_count] = '{number: number & NUM_MASK, low: low};
                    stack_count++;
                end
            end
            OP_POP: begin
                if (stack_count == 0) res.status = ST_EMPTY;
                else stack_count--;
            end
            OP_PEEK_BOT: begin
                if (stack_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.number = stack_mem[0].number;
                    res.low    = stack_mem[0].low;
                    res.valid  = 1'b1;
                end
            end
            OP_REORDER: begin
                if (stack_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // level 2 records sink to the bottom, level 1 above, order kept
                    k = 0;
                    for (int i = 0; i < stack_count; i++) begin
                        if (stack_mem[i].low) begin
                            scratch_mem[k] = stack_mem[i];
                            k++;
                        end
                    end
                    for (int i = 0; i < stack_count; i++) begin
                        if (!stack_mem[i].low) begin
                            scratch_mem[k] = stack_mem[i];
                            k++;
                        end
                    end
                    for (int i = 0; i < k; i++) stack_mem[i] = scratch_mem[i];
                end
            end
            OP_MOVE: begin
                if (stack_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < stack_count; i++) begin
                        queue_mem[i] = stack_mem[stack_count - 1 - i];
                    end
                    queue_head  = 0;
                    queue_count = stack_count;
                    stack_count = 0;
                end
            end
            OP_PEEK_Q, OP_DEQUEUE: begin
                if (queue_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.number = queue_mem[queue_head].number;
                    res.low    = queue_mem[queue_head].low;
                    res.valid  = 1'b1;
                    if (op == OP_DEQUEUE) begin
                        queue_head = (queue_head + 1) % STACK_DEPTH;
                        queue_count--;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_word(t_op op, logic [15:0] number, logic low);
        words_to_send.push_back('{op: op, number: number, low: low});
        if (op != OP_NONE) counted_words++;
    endtask

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return OP_PUSH;
        if (r < 45) return OP_POP;
        if (r < 55) return OP_PEEK_BOT;
        if (r < 63) return OP_REORDER;
        if (r < 70) return OP_MOVE;
        if (r < 80) return OP_PEEK_Q;
        if (r < 95) return OP_DEQUEUE;
        return OP_NONE;
    endfunction

    task automatic note_failure(string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    // sender: bursts of words separated by random gaps
    t_word send_word;
    int    burst_left = 1;
    int    gap_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                    i_op <= t_op'($urandom_range(0, 7));
                    i_record_number <= 16'($urandom);
                    i_low_priority <= 1'($urandom_range(0, 1));
                end else if (words_to_send.size() != 0) begin
                    send_word = words_to_send.pop_front();
                    i_op <= send_word.op;
                    i_record_number <= send_word.number;
                    i_low_priority <= send_word.low;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 3);
                            2: gap_left = $urandom_range(4, 12);
                            default: gap_left = $urandom_range(13, 40);
                        endcase
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switching between modes
    int   rx_mode = 0;
    int   rx_tick = 0;
    logic rx_go;
    int   hold_left = 0;

    always @(negedge i_clk) begin
        if (rx_tick == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_tick = $urandom_range(16, 120);
        end else begin
            rx_tick = rx_tick - 1;
        end
        case (rx_mode)
            0: rx_go = 1'b1;
            1: rx_go = 1'($urandom_range(0, 1));
            2: rx_go = (rx_tick % 4 == 0);
            default: rx_go = ($urandom_range(0, 9) != 0);
        endcase
        i_ready <= rx_go && (hold_left == 0);
    end

    // long output hold-off so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (i_rst_n && i_valid && o_ready && (words_in == 300 || words_in == 800)) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // monitor and checker
    t_outcome want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected word: status %0d number %h low %b valid %b",
                        o_status, o_out_number, o_out_low_priority, o_out_valid));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_out_number !== want.number ||
                        o_out_low_priority !== want.low || o_out_valid !== want.valid) begin
                        note_failure($sformatf({"mismatch: expected status %0d number %h ",
                            "low %b valid %b, got status %0d number %h low %b valid %b"},
                            want.status, want.number, want.low, want.valid,
                            o_status, o_out_number, o_out_low_priority, o_out_valid));
                    end
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(stack_queue_result(i_op, i_record_number,
                    i_low_priority));
                words_in <= words_in + 1;
            end
        end
    end

    initial begin
        int n;
        int pmode;
        // empty cases and the unused op
        add_word(OP_POP, 16'hA5A5, 1'b1);
        add_word(OP_PEEK_BOT, 16'h5A5A, 1'b0);
        add_word(OP_REORDER, 16'hFFFF, 1'b1);
        add_word(OP_MOVE, 16'h0000, 1'b0);
        add_word(OP_PEEK_Q, 16'h1234, 1'b1);
        add_word(OP_DEQUEUE, 16'hFFFF, 1'b1);
        add_word(OP_NONE, 16'hFFFF, 1'b1);
        // extreme records, reorder, move and queue drain to empty
        add_word(OP_PUSH, 16'hFFFF, 1'b1);
        add_word(OP_PUSH, 16'h0000, 1'b0);
        add_word(OP_PUSH, 16'h8000, 1'b1);
        add_word(OP_PUSH, 16'h7FFF, 1'b0);
        add_word(OP_PEEK_BOT, 16'h0000, 1'b0);
        add_word(OP_REORDER, 16'h0000, 1'b0);
        add_word(OP_PEEK_BOT, 16'hFFFF, 1'b1);
        add_word(OP_POP, 16'h0000, 1'b0);
        add_word(OP_MOVE, 16'hFFFF, 1'b1);
        add_word(OP_PEEK_Q, 16'h0000, 1'b0);
        repeat (3) add_word(OP_DEQUEUE, 16'h0000, 1'b0);
        add_word(OP_DEQUEUE, 16'hFFFF, 1'b1);
        counted_words = 0;

        while (counted_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // push run, often past full, with a fixed or mixed priority
                    pmode = $urandom_range(0, 2);
                    n = $urandom_range(1, 20);
                    repeat (n) begin
                        add_word(OP_PUSH, 16'($urandom),
                            pmode == 0 ? 1'($urandom_range(0, 1)) : (pmode == 2));
                    end
                    if ($urandom_range(0, 1)) add_word(OP_REORDER, 16'($urandom), 1'b0);
                    if ($urandom_range(0, 1)) add_word(OP_PEEK_BOT, 16'($urandom), 1'b1);
                end
                3, 4, 5: begin
                    // move then drain the queue, sometimes past empty
                    add_word(OP_MOVE, 16'($urandom), 1'($urandom_range(0, 1)));
                    n = $urandom_range(1, 18);
                    repeat (n) begin
                        add_word($urandom_range(0, 3) == 0 ? OP_PEEK_Q : OP_DEQUEUE,
                            16'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
                6, 7, 8: begin
                    repeat (12) add_word(pick_op(), 16'($urandom), 1'($urandom_range(0, 1)));
                end
                default: begin
                    repeat (6) begin
                        add_word(t_op'($urandom_range(0, 7)), 16'($urandom),
                            1'($urandom_range(0, 1)));
                    end
                end
            endcase
        end
        words_total = words_to_send.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_in != words_total) @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/pstq_pkg.sv
sv/pstq_ram.sv
sv/priority_stack_to_queue.sv
bench/tb_top.sv
